// ===== src/petri_net_reachability_explorer_defines.svh =====
// assertion macros shared by the rtl
`ifndef PETRI_NET_REACHABILITY_EXPLORER_DEFINES_SVH
`define PETRI_NET_REACHABILITY_EXPLORER_DEFINES_SVH

// a property that must hold at every clock edge out of reset
`define PNR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// an implication whose consequent is checked in the cycle after the antecedent
`define PNR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pnr_pkg.sv =====
`timescale 1ns / 1ps
package pnr_pkg;
    localparam int PLACES      = 12;
    localparam int TRANSITIONS = 12;
    localparam int TOKEN_BITS  = 4;
    localparam int MAX_STATES  = 64;
    localparam int WORD_BITS   = PLACES * TOKEN_BITS;
    localparam int TIDX_BITS   = 4;
    localparam int SIDX_BITS   = 6;
    localparam int CNT_BITS    = 7;
    localparam int IN_BITS     = 152;
    localparam int OUT_BITS    = 56;

    localparam logic [1:0] REG_PLACES      = 2'd0;
    localparam logic [1:0] REG_TRANSITIONS = 2'd1;
    localparam logic [1:0] REG_LIMIT       = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR_WAIT,
        ST_VISIT_RD,
        ST_VISIT_WAIT,
        ST_FIRE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_APPEND,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } state_t;

    // result of the lanes for one transition
    typedef struct packed {
        logic  enabled;
        logic  sat;
        word_t next_marking;
    } fire_t;
endpackage

// ===== src/pnr_ram.sv =====
`timescale 1ns / 1ps
module pnr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/pnr_lane.sv =====
`timescale 1ns / 1ps
module pnr_lane (
    input  logic                                cur_on,
    input  logic [pnr_pkg::TOKEN_BITS-1:0]      cur_tok,
    input  logic [pnr_pkg::TOKEN_BITS-1:0]      weight,
    input  logic [pnr_pkg::TOKEN_BITS-1:0]      change,
    output logic                                ok,
    output logic                                sat,
    output logic [pnr_pkg::TOKEN_BITS-1:0]      next_tok
);
    import pnr_pkg::*;

    logic signed [TOKEN_BITS+1:0] sum;

    always_comb
    begin
        sum = $signed({2'b00, cur_tok}) + $signed({{2{change[TOKEN_BITS-1]}}, change});
        ok  = !cur_on || (cur_tok >= weight);
        sat = 1'b0;
        next_tok = sum[TOKEN_BITS-1:0];
        if (!cur_on)
        begin
            next_tok = '0;
        end
        else if (sum < 0)
        begin
            next_tok = '0;
            sat = 1'b1;
        end
        else if (sum > $signed({2'b00, {TOKEN_BITS{1'b1}}}))
        begin
            next_tok = '1;
            sat = 1'b1;
        end
    end
endmodule

// ===== src/pnr_merge.sv =====
`timescale 1ns / 1ps
module pnr_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pnr_pkg::PLACES-1:0]    lane_ok,
    input  logic [pnr_pkg::PLACES-1:0]    lane_sat,
    input  pnr_pkg::word_t                lane_word,
    output pnr_pkg::fire_t                fire
);
    import pnr_pkg::*;

    logic  enabled_reg;
    logic  sat_reg;
    word_t marking_reg;

    // combine lanes and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            enabled_reg <= &lane_ok;
            sat_reg     <= |lane_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        marking_reg <= lane_word;
    end

    assign fire = {enabled_reg, sat_reg, marking_reg};
endmodule

// ===== src/petri_net_reachability_explorer.sv =====
`timescale 1ns / 1ps
// Breadth-first reachability explorer for a small Petri net. Load words
// (opcode 0) write one transition's enabling weights and token changes; a
// start word (opcode 1) walks all reachable markings from the initial one and
// then streams them out in discovery order, last_state on the final one. Twelve
// place lanes test and fire one transition together, and the merge stage
// registers their result; each new marking is then checked against the store
// one entry per cycle through the store RAM's single read port.
module petri_net_reachability_explorer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, transition_index, enable_weights, token_change, initial_marking
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // marking, state_number, last_state, overflow
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);
    import pnr_pkg::*;
    `include "petri_net_reachability_explorer_defines.svh"

    // configuration
    logic [3:0] places_reg, trans_reg;
    logic [6:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            places_reg <= 4'd12;
            trans_reg  <= 4'd12;
            limit_reg  <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLACES:      places_reg <= cfg_data[3:0];
                REG_TRANSITIONS: trans_reg  <= cfg_data[3:0];
                REG_LIMIT:       limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // clamped settings
    logic [4:0] np, nt;
    logic [6:0] lim;
    always_comb
    begin
        np  = (places_reg == 0) ? 5'd1 : ((places_reg > PLACES) ? 5'(PLACES) : {1'b0, places_reg});
        nt  = (trans_reg == 0) ? 5'd1 : ((trans_reg > TRANSITIONS) ? 5'(TRANSITIONS)
              : {1'b0, trans_reg});
        lim = (limit_reg == 0) ? 7'd1 : ((limit_reg > MAX_STATES) ? 7'(MAX_STATES) : limit_reg);
    end

    // input fields
    logic       in_op;
    logic [3:0] in_tidx;
    word_t      in_en, in_ch, in_init;
    assign in_op   = s_tdata[0];
    assign in_tidx = s_tdata[4:1];
    assign in_en   = s_tdata[52:5];
    assign in_ch   = s_tdata[100:53];
    assign in_init = s_tdata[148:101];

    // transition tables, small and read at one place
    word_t en_tab [TRANSITIONS];
    word_t ch_tab [TRANSITIONS];

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [SIDX_BITS-1:0] visit_reg, visit_next;
    logic [SIDX_BITS-1:0] search_reg, search_next;
    logic [TIDX_BITS-1:0] t_reg, t_next;
    logic                 ovf_reg, ovf_next;
    word_t                cur_reg, cur_next;
    word_t                cand_reg, cand_next;

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (s_fire && in_op == OP_LOAD && in_tidx < TRANSITIONS)
        begin
            en_tab[in_tidx] <= in_en;
            ch_tab[in_tidx] <= in_ch;
        end
    end

    // place mask for unused places
    word_t pmask;
    always_comb
    begin
        for (int p = 0; p < PLACES; p++)
        begin
            pmask[p*TOKEN_BITS +: TOKEN_BITS] = (p < np) ? '1 : '0;
        end
    end

    // lanes
    logic [PLACES-1:0] lane_ok, lane_sat;
    word_t             lane_word;
    word_t             cur_en, cur_ch;
    assign cur_en = en_tab[t_reg];
    assign cur_ch = ch_tab[t_reg];

    for (genvar g = 0; g < PLACES; g++)
    begin : g_lane
        pnr_lane u_lane (
            .cur_on   (g < np),
            .cur_tok  (cur_reg[g*TOKEN_BITS +: TOKEN_BITS]),
            .weight   (cur_en[g*TOKEN_BITS +: TOKEN_BITS]),
            .change   (cur_ch[g*TOKEN_BITS +: TOKEN_BITS]),
            .ok       (lane_ok[g]),
            .sat      (lane_sat[g]),
            .next_tok (lane_word[g*TOKEN_BITS +: TOKEN_BITS])
        );
    end

    fire_t fire;
    pnr_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ok   (lane_ok),
        .lane_sat  (lane_sat),
        .lane_word (lane_word),
        .fire      (fire)
    );

    // reached store
    logic                 ram_we;
    logic [SIDX_BITS-1:0] ram_waddr, ram_raddr;
    word_t                ram_wdata, ram_rdata;

    pnr_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_STATES)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]  out_data_reg, out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            visit_reg     <= '0;
            search_reg    <= '0;
            t_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            visit_reg     <= visit_next;
            search_reg    <= search_next;
            t_reg         <= t_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        cand_reg     <= cand_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        visit_next     = visit_reg;
        search_next    = search_reg;
        t_next         = t_reg;
        ovf_next       = ovf_reg;
        cur_next       = cur_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = in_init & pmask;
        ram_raddr      = visit_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && in_op == OP_START)
                begin
                    ram_we     = 1'b1;
                    count_next = 7'd1;
                    visit_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_CLEAR_WAIT;
                end
            end
            ST_CLEAR_WAIT:
            begin
                state_next = ST_VISIT_RD;
            end
            ST_VISIT_RD:
            begin
                // visit_reg addresses the store
                if ({1'b0, visit_reg} >= count_reg)
                begin
                    visit_next = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_VISIT_WAIT;
                end
            end
            ST_VISIT_WAIT:
            begin
                cur_next   = ram_rdata;
                t_next     = '0;
                state_next = ST_FIRE;
            end
            ST_FIRE:
            begin
                // merge stage registers the lanes this cycle
                search_next = '0;
                state_next  = ST_SEARCH_RD;
            end
            ST_SEARCH_RD:
            begin
                if (!fire.enabled)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    if (fire.sat)
                    begin
                        ovf_next = 1'b1;
                    end
                    cand_next  = fire.next_marking;
                    ram_raddr  = search_reg;
                    state_next = ST_SEARCH_CMP;
                end
            end
            ST_SEARCH_CMP:
            begin
                ram_raddr = search_reg + 6'd1;
                if (ram_rdata == cand_reg)
                begin
                    state_next = ST_APPEND;
                end
                else if ({1'b0, search_reg} + 7'd1 >= count_reg)
                begin
                    if (count_reg >= lim)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[SIDX_BITS-1:0];
                        ram_wdata  = cand_reg;
                        count_next = count_reg + 7'd1;
                    end
                    state_next = ST_APPEND;
                end
                else
                begin
                    search_next = search_reg + 6'd1;
                end
            end
            ST_APPEND:
            begin
                // advance to next transition or next marking, or to emitting after the last
                if ({1'b0, t_reg} + 5'd1 >= nt)
                begin
                    if ({1'b0, visit_reg} + 7'd1 >= count_reg)
                    begin
                        visit_next = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        visit_next = visit_reg + 6'd1;
                        state_next = ST_VISIT_RD;
                    end
                end
                else
                begin
                    t_next     = t_reg + 4'd1;
                    state_next = ST_FIRE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ovf_reg, ({1'b0, visit_reg} + 7'd1 == count_reg),
                                      visit_reg, ram_rdata};
                    state_next     = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT:
            begin
                if ({1'b0, visit_reg} + 7'd1 >= count_reg)
                begin
                    visit_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    visit_next = visit_reg + 6'd1;
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_valid_reg && m_tready && !(state_reg == ST_EMIT_WAIT && out_valid_next))
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PNR_ASSERT(a_count_bound, clk, rst_n, count_reg <= 7'(MAX_STATES), "store count past depth")
    `PNR_ASSERT(a_idle_no_count, clk, rst_n, !(state_reg == ST_FIRE && count_reg == '0),
        "firing with empty store")
    `PNR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")
endmodule
